FILE: design/lbvs_pkg.sv
// ----------------------------------------------------------------------------
// lbvs_pkg
// shared types and constants of the four-influence skinning block
// ----------------------------------------------------------------------------
package lbvs_pkg;

  localparam int unsigned JOINT_SLOTS = 32;
  localparam int unsigned ELEMS       = 12;
  localparam int unsigned PAL_DEPTH   = JOINT_SLOTS * ELEMS;
  localparam int unsigned PAL_AW      = $clog2(PAL_DEPTH);
  localparam int unsigned JW          = $clog2(JOINT_SLOTS);
  localparam int unsigned LIM_W       = $clog2(JOINT_SLOTS + 1) + 1;
  localparam int unsigned FIFO_DEPTH  = 4;
  localparam int unsigned FIFO_AW     = $clog2(FIFO_DEPTH);
  localparam int unsigned TOT_W       = 10;
  localparam int unsigned ACC_W       = 42;
  localparam int unsigned SUM_W       = 60;
  localparam int unsigned NRM_W       = 52;
  localparam int unsigned SQ_W        = 104;
  localparam int unsigned MUL_W       = 120;

  localparam logic [0:0] REG_JOINT_COUNT = 1'b0;
  localparam logic [0:0] REG_NORMALS     = 1'b1;
  localparam logic       CMD_WRITE       = 1'b0;
  localparam logic       CMD_VERTEX      = 1'b1;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_JOINT,
    ERR_WEIGHT,
    ERR_RANGE
  } err_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC,
    ST_DRAIN,
    ST_POS,
    ST_RCHK,
    ST_DIV,
    ST_NORM,
    ST_NZ,
    ST_SQ_LD,
    ST_SQ_RUN,
    ST_SR_LD,
    ST_SR_RUN,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic               cmd;
    logic [4:0]         write_joint;
    logic [3:0]         write_element;
    logic signed [31:0] write_value;
    logic signed [15:0] bind_x;
    logic signed [15:0] bind_y;
    logic signed [15:0] bind_z;
    logic [31:0]        joint_indices;
    logic [31:0]        weights;
    logic [23:0]        normal_in;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [7:0]  norm_x;
    logic signed [7:0]  norm_y;
    logic signed [7:0]  norm_z;
    logic               normal_valid;
    err_e               error_code;
  } out_word_t;

  typedef struct packed {
    in_word_t         word;
    err_e             err;
    logic [TOT_W-1:0] total;
  } job_t;

endpackage

FILE: design/lbvs_front.sv
// ----------------------------------------------------------------------------
// lbvs_front
// config registers, joint range check and weight total of incoming words
// ----------------------------------------------------------------------------
module lbvs_front import lbvs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_word_i,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [5:0] cfg_data_i,
  output logic       job_valid_o,
  input  logic       job_ready_i,
  output job_t       job_o,
  output logic       normals_en_o
);

  logic [5:0] joint_count_q;
  logic       normals_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      joint_count_q <= 6'd32;
      normals_q     <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_JOINT_COUNT: joint_count_q <= cfg_data_i;
        REG_NORMALS:     normals_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    logic [LIM_W-1:0] lim;
    logic [TOT_W-1:0] total;
    logic             bad;
    logic [7:0]       w;
    logic [7:0]       jj;
    lim   = (LIM_W'(joint_count_q) > LIM_W'(JOINT_SLOTS)) ? LIM_W'(JOINT_SLOTS)
                                                          : LIM_W'(joint_count_q);
    total = '0;
    bad   = 1'b0;
    for (int s = 0; s < 4; s++) begin
      w  = in_word_i.weights[8*s +: 8];
      jj = in_word_i.joint_indices[8*s +: 8];
      if (w != 8'd0 && !bad) begin
        if ((LIM_W + 8)'(jj) >= (LIM_W + 8)'(lim)) begin
          bad = 1'b1;
        end else begin
          total = total + TOT_W'(w);
        end
      end
    end
    job_o.word  = in_word_i;
    job_o.total = total;
    if (bad) begin
      job_o.err = ERR_JOINT;
    end else if (total == '0) begin
      job_o.err = ERR_WEIGHT;
    end else begin
      job_o.err = ERR_NONE;
    end
  end

  assign job_valid_o  = in_valid_i;
  assign in_ready_o   = job_ready_i;
  assign normals_en_o = normals_q;

endmodule

FILE: design/lbvs_fifo.sv
// ----------------------------------------------------------------------------
// lbvs_fifo
// short job queue between the front and the back end
// ----------------------------------------------------------------------------
module lbvs_fifo import lbvs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_i,
  output job_t pop_data_o
);

  job_t               mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr_q, rptr_q;
  logic [FIFO_AW:0]   cnt_q;
  logic               push, pop;

  assign push_ready_o = (cnt_q != (FIFO_AW + 1)'(FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;
  assign pop_data_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) wptr_q <= wptr_q + 1'b1;
      if (pop)  rptr_q <= rptr_q + 1'b1;
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wptr_q] <= push_data_i;
  end

endmodule

FILE: design/lbvs_back.sv
// ----------------------------------------------------------------------------
// lbvs_back
// palette memory, blend, divide and normal rescale sequencer, result register
// ----------------------------------------------------------------------------
module lbvs_back import lbvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_pop_o,
  input  job_t      job_i,
  input  logic      normals_en_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_word_t out_word_o
);

  logic signed [31:0] pal_mem [PAL_DEPTH];

  state_e st_q, st_d;
  job_t   job_q;
  err_e   err_q;
  logic   nv_q;

  logic [1:0]         inf_q;
  logic [3:0]         elem_q;
  logic signed [31:0] rd_data_q;
  logic [7:0]         rd_w_q;
  logic [3:0]         rd_e_q;
  logic               rd_v_q;

  logic signed [ACC_W-1:0] acc_q [ELEMS];
  logic signed [SUM_W-1:0] s_q [3];
  logic signed [NRM_W-1:0] n_q [3];
  logic signed [15:0]      pos_q [3];
  logic signed [7:0]       nrm_q [3];
  logic [SQ_W-1:0]         sq_q [3];
  logic [MUL_W-1:0]        sumsq_q;

  logic [1:0]   r_q, c_q;
  logic [3:0]   bit_q;
  logic [24:0]  rem_q;
  logic [14:0]  quo_q;
  logic [6:0]   q_q;
  logic [MUL_W-1:0] ma_q, macc_q;
  logic [NRM_W-1:0] mb_q;
  logic [5:0]   mcnt_q;

  out_word_t out_q;
  logic      out_valid_q;

  logic [7:0]        cur_w;
  logic [JW-1:0]     cur_j;
  logic [PAL_AW-1:0] rd_addr, wr_addr;
  logic              pal_we, is_vertex, out_free;
  logic [3:0]        pidx, nidx;
  logic signed [15:0] bsel;
  logic signed [57:0] prod_p;
  logic signed [NRM_W-1:0] nsum;
  logic [SUM_W-1:0]  sabs [3];
  logic [24:0]       lim25, tsh, remn;
  logic [40:0]       lim;
  logic              range_bad, ge, nz_zero;
  logic [14:0]       quon;
  logic signed [15:0] posv;
  logic [NRM_W-1:0]  mag;
  logic [MUL_W-1:0]  mstep, rhs, sqr;
  logic [6:0]        cand, qsel;
  logic [13:0]       csq;
  logic signed [7:0] nval;
  out_word_t         res;

  assign out_free  = !out_valid_q || out_ready_i;
  assign is_vertex = (job_i.word.cmd == CMD_VERTEX);
  assign job_pop_o = (st_q == ST_IDLE) && job_valid_i;
  assign pal_we    = job_pop_o && !is_vertex
                     && (32'(job_i.word.write_joint) < JOINT_SLOTS)
                     && (32'(job_i.word.write_element) < ELEMS);
  assign wr_addr   = PAL_AW'(32'(job_i.word.write_joint) * ELEMS
                     + 32'(job_i.word.write_element));
  assign cur_w     = job_q.word.weights[{inf_q, 3'b000} +: 8];
  assign cur_j     = job_q.word.joint_indices[{inf_q, 3'b000} +: JW];
  assign rd_addr   = PAL_AW'(32'(cur_j) * ELEMS + 32'(elem_q));

  always_ff @(posedge clk_i) begin
    if (pal_we) pal_mem[wr_addr] <= job_i.word.write_value;
    rd_data_q <= pal_mem[rd_addr];
  end

  always_comb begin
    pidx = 4'({r_q, 1'b0}) + 4'(r_q) + 4'(c_q);
    nidx = 4'({r_q, 1'b0}) + 4'(r_q);
    unique case (c_q)
      2'd0:    bsel = job_q.word.bind_x;
      2'd1:    bsel = job_q.word.bind_y;
      default: bsel = job_q.word.bind_z;
    endcase
    prod_p = acc_q[pidx] * bsel;
    nsum = acc_q[nidx] * $signed(job_q.word.normal_in[7:0])
         + acc_q[nidx + 4'd1] * $signed(job_q.word.normal_in[15:8])
         + acc_q[nidx + 4'd2] * $signed(job_q.word.normal_in[23:16]);
    for (int i = 0; i < 3; i++) begin
      sabs[i] = s_q[i][SUM_W-1] ? SUM_W'(-s_q[i]) : SUM_W'(s_q[i]);
    end
    lim25 = 25'({job_q.total, 15'b0}) - 25'(job_q.total);
    lim   = {lim25, 16'b0};
    range_bad = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (sabs[i] >= SUM_W'(lim)) range_bad = 1'b1;
    end
    tsh  = 25'(job_q.total) << bit_q;
    ge   = (rem_q >= tsh);
    remn = ge ? rem_q - tsh : rem_q;
    quon = ge ? (quo_q | (15'd1 << bit_q)) : quo_q;
    posv = s_q[r_q][SUM_W-1] ? -$signed({1'b0, quon}) : $signed({1'b0, quon});
    nz_zero = (n_q[0] == '0) && (n_q[1] == '0) && (n_q[2] == '0);
    mag   = n_q[r_q][NRM_W-1] ? NRM_W'(-n_q[r_q]) : NRM_W'(n_q[r_q]);
    mstep = macc_q + (mb_q[0] ? ma_q : '0);
    sqr   = MUL_W'(sq_q[r_q]);
    rhs   = (sqr << 14) - (sqr << 8) + sqr;
    cand  = q_q | (7'd1 << bit_q);
    csq   = 14'(cand) * 14'(cand);
    qsel  = (mstep <= rhs) ? cand : q_q;
    nval  = n_q[r_q][NRM_W-1] ? -$signed({1'b0, qsel}) : $signed({1'b0, qsel});
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      ST_IDLE:   if (job_valid_i && is_vertex) begin
                   st_d = (job_i.err != ERR_NONE) ? ST_DONE : ST_ACC;
                 end
      ST_ACC:    if (inf_q == 2'd3 && elem_q == 4'(ELEMS - 1)) st_d = ST_DRAIN;
      ST_DRAIN:  st_d = ST_POS;
      ST_POS:    if (r_q == 2'd2 && c_q == 2'd2) st_d = ST_RCHK;
      ST_RCHK:   st_d = range_bad ? ST_DONE : ST_DIV;
      ST_DIV:    if (bit_q == 4'd0 && r_q == 2'd2) begin
                   st_d = normals_en_i ? ST_NORM : ST_DONE;
                 end
      ST_NORM:   if (r_q == 2'd2) st_d = ST_NZ;
      ST_NZ:     st_d = nz_zero ? ST_DONE : ST_SQ_LD;
      ST_SQ_LD:  st_d = ST_SQ_RUN;
      ST_SQ_RUN: if (mcnt_q == '0) st_d = (r_q == 2'd2) ? ST_SR_LD : ST_SQ_LD;
      ST_SR_LD:  st_d = ST_SR_RUN;
      ST_SR_RUN: if (mcnt_q == '0) begin
                   st_d = (bit_q == 4'd0 && r_q == 2'd2) ? ST_DONE : ST_SR_LD;
                 end
      ST_DONE:   if (out_free) st_d = ST_IDLE;
      default:   st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    res = '0;
    res.error_code = err_q;
    if (err_q == ERR_NONE) begin
      res.pos_x = pos_q[0];
      res.pos_y = pos_q[1];
      res.pos_z = pos_q[2];
      if (nv_q) begin
        res.norm_x       = nrm_q[0];
        res.norm_y       = nrm_q[1];
        res.norm_z       = nrm_q[2];
        res.normal_valid = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      rd_v_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      rd_v_q <= (st_q == ST_ACC) && (cur_w != 8'd0);
      if (st_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_w_q <= cur_w;
    rd_e_q <= elem_q;
    if (st_q == ST_DONE && out_free) out_q <= res;
    if (st_q == ST_IDLE) begin
      for (int i = 0; i < ELEMS; i++) acc_q[i] <= '0;
    end else if (rd_v_q) begin
      acc_q[rd_e_q] <= acc_q[rd_e_q] + $signed({1'b0, rd_w_q}) * rd_data_q;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        job_q  <= job_i;
        err_q  <= job_i.err;
        nv_q   <= 1'b0;
        inf_q  <= '0;
        elem_q <= '0;
      end
      ST_ACC: begin
        if (elem_q == 4'(ELEMS - 1)) begin
          elem_q <= '0;
          inf_q  <= inf_q + 2'd1;
        end else begin
          elem_q <= elem_q + 4'd1;
        end
      end
      ST_DRAIN: begin
        r_q <= '0;
        c_q <= '0;
      end
      ST_POS: begin
        s_q[r_q] <= ((c_q == 2'd0) ? acc_q[4'd9 + 4'(r_q)] : s_q[r_q]) + prod_p;
        if (c_q == 2'd2) begin
          c_q <= '0;
          r_q <= r_q + 2'd1;
        end else begin
          c_q <= c_q + 2'd1;
        end
      end
      ST_RCHK: begin
        if (range_bad) err_q <= ERR_RANGE;
        r_q   <= '0;
        bit_q <= 4'd14;
        rem_q <= sabs[0][40:16];
        quo_q <= '0;
      end
      ST_DIV: begin
        rem_q <= remn;
        quo_q <= quon;
        if (bit_q == 4'd0) begin
          pos_q[r_q] <= posv;
          if (r_q != 2'd2) begin
            r_q   <= r_q + 2'd1;
            bit_q <= 4'd14;
            rem_q <= sabs[r_q + 2'd1][40:16];
            quo_q <= '0;
          end else begin
            r_q <= '0;
          end
        end else begin
          bit_q <= bit_q - 4'd1;
        end
      end
      ST_NORM: begin
        n_q[r_q] <= nsum;
        r_q      <= (r_q == 2'd2) ? 2'd0 : r_q + 2'd1;
      end
      ST_NZ: begin
        sumsq_q <= '0;
        r_q     <= '0;
      end
      ST_SQ_LD: begin
        ma_q   <= MUL_W'(mag);
        mb_q   <= mag;
        macc_q <= '0;
        mcnt_q <= 6'(NRM_W - 1);
      end
      ST_SQ_RUN: begin
        macc_q <= mstep;
        ma_q   <= ma_q << 1;
        mb_q   <= mb_q >> 1;
        mcnt_q <= mcnt_q - 6'd1;
        if (mcnt_q == '0) begin
          sq_q[r_q] <= mstep[SQ_W-1:0];
          sumsq_q   <= sumsq_q + mstep;
          if (r_q == 2'd2) begin
            r_q   <= '0;
            bit_q <= 4'd6;
            q_q   <= '0;
          end else begin
            r_q <= r_q + 2'd1;
          end
        end
      end
      ST_SR_LD: begin
        ma_q   <= sumsq_q;
        mb_q   <= NRM_W'(csq);
        macc_q <= '0;
        mcnt_q <= 6'd13;
      end
      ST_SR_RUN: begin
        macc_q <= mstep;
        ma_q   <= ma_q << 1;
        mb_q   <= mb_q >> 1;
        mcnt_q <= mcnt_q - 6'd1;
        if (mcnt_q == '0) begin
          if (bit_q == 4'd0) begin
            nrm_q[r_q] <= nval;
            q_q        <= '0;
            bit_q      <= 4'd6;
            if (r_q == 2'd2) begin
              nv_q <= 1'b1;
            end else begin
              r_q <= r_q + 2'd1;
            end
          end else begin
            q_q   <= qsel;
            bit_q <= bit_q - 4'd1;
          end
        end
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

FILE: design/linear_blend_vertex_skinning_top.sv
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_top
// four-influence linear blend skinning with a joint palette
// ----------------------------------------------------------------------------
// input channel: in_valid_i / in_ready_o carry one word, either a palette
// element write (cmd 0) or a vertex to skin (cmd 1). output channel:
// out_valid_o / out_ready_i carry one result word per vertex, none per write.
// config: cfg_we_i writes cfg_data_i into register cfg_index_i (0 joint
// count, 1 normals enable); the user must write only while the block is
// idle, and the block itself does not enforce this. words pass a 4-entry
// queue, so input is taken while the back end works and while a finished
// result waits in the output register. a palette write is done as it
// leaves the queue. a vertex takes 48 palette reads through the single
// read port, a 15-step divider per axis for the position and, with
// normals on, a bit-serial multiplier for the normal rescale; a bad joint
// or zero weight total skips all three; a range error skips the last two.
// reset: palette contents undefined, joint count 32, normals enabled, queue
// and output register empty. a stalled receiver holds the result steady; the
// back end then waits and the queue fills before in_ready_o drops.
// ----------------------------------------------------------------------------
module linear_blend_vertex_skinning_top import lbvs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_word_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_word_t  out_word_o,
  input  logic       cfg_we_i,
  input  logic [0:0] cfg_index_i,
  input  logic [5:0] cfg_data_i
);

  logic job_valid, job_ready, head_valid, head_pop, normals_en;
  job_t job, head;

  lbvs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_word_i    (in_word_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .job_valid_o  (job_valid),
    .job_ready_i  (job_ready),
    .job_o        (job),
    .normals_en_o (normals_en)
  );

  lbvs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (job_valid),
    .push_ready_o (job_ready),
    .push_data_i  (job),
    .pop_valid_o  (head_valid),
    .pop_i        (head_pop),
    .pop_data_o   (head)
  );

  lbvs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (head_valid),
    .job_pop_o    (head_pop),
    .job_i        (head),
    .normals_en_i (normals_en),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_word_o   (out_word_o)
  );

endmodule

FILE: design/lbvs_checker.sv
// ----------------------------------------------------------------------------
// lbvs_checker
// port-level checks of the skinning block, bound to the top level
// ----------------------------------------------------------------------------
module lbvs_checker import lbvs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_word_t out_word_o
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while stalled");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.error_code != ERR_NONE |->
      out_word_o.pos_x == 16'sd0 && out_word_o.pos_y == 16'sd0 &&
      out_word_o.pos_z == 16'sd0 && out_word_o.normal_valid == 1'b0 &&
      out_word_o.norm_x == 8'sd0 && out_word_o.norm_y == 8'sd0 &&
      out_word_o.norm_z == 8'sd0)
    else $error("error word carries data");

  a_norm_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_word_o.normal_valid |->
      out_word_o.norm_x == 8'sd0 && out_word_o.norm_y == 8'sd0 &&
      out_word_o.norm_z == 8'sd0)
    else $error("normal without normal_valid");

  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      out_word_o.norm_x != -8'sd128 && out_word_o.norm_y != -8'sd128 &&
      out_word_o.norm_z != -8'sd128 && out_word_o.pos_x != -16'sd32768 &&
      out_word_o.pos_y != -16'sd32768 && out_word_o.pos_z != -16'sd32768)
    else $error("result field out of range");

endmodule

bind linear_blend_vertex_skinning_top lbvs_checker u_lbvs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_word_o  (out_word_o)
);
